FILE: design/tfz_pkg.sv
package tfz_pkg;

  localparam int VALUE_BITS = 16;
  localparam int TERM_W     = 3;
  localparam int QB         = 15;
  localparam int RW         = VALUE_BITS + 1;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QB / DIV_STEPS;

  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_FUZZ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_BP      = 2'd0,
    KIND_PEAK    = 2'd1,
    KIND_SUPPORT = 2'd2
  } kind_t;

  typedef struct packed {
    op_t                          operation;
    logic signed [VALUE_BITS-1:0] deviation;
    logic signed [VALUE_BITS-1:0] trend;
    logic                         load_channel;
    logic [1:0]                   load_kind;
    logic [2:0]                   load_index;
    logic signed [VALUE_BITS-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic        channel;
    logic [2:0]  term;
    logic [15:0] membership;
    logic        last;
  } out_item_t;

  // region of one sample: first term and whether two terms follow
  typedef struct packed {
    logic [TERM_W-1:0] base;
    logic              pair;
  } region_t;

  typedef struct packed {
    logic                         valid;
    logic                         channel;
    logic [TERM_W-1:0]            term;
    logic                         last;
    logic                         full;
    logic signed [VALUE_BITS-1:0] v;
    logic signed [VALUE_BITS-1:0] p;
    logic signed [VALUE_BITS-1:0] s;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic              channel;
    logic [TERM_W-1:0] term;
    logic              last;
    logic              full;
    logic              zero;
    logic [RW-1:0]     r;
    logic [RW-1:0]     s;
    logic [QB-1:0]     q;
  } div_t;

endpackage

FILE: design/two_input_triangular_fuzzifier.sv
// Triangular fuzzifier for a deviation and a trend sample. A load request
// writes one breakpoint, peak or support word of one channel's table; the
// tables come up undefined and must be loaded before use. A fuzzify request
// gives two to four results: channel 0 first, then channel 1, lower term
// first, with last set on the final one. Membership is
// 1 - 2|v - peak| / support in Q1.15, clamped at 0, and 1.0 in both end
// regions. Rate: job issue takes a new request as the one before finishes
// there, and starts one membership per cycle into the divider pipe unless
// the output stalls. A request passes the input, region, job and offset
// stages, five divider stages and the output register. A stalled output
// freezes the whole pipe in place.
module two_input_triangular_fuzzifier #(
  parameter int TERMS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfz_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tfz_pkg::out_item_t out_data
);
  import tfz_pkg::*;

  localparam int AW = $clog2(2 * TERMS);

  // pipe advance: only a held output result freezes the pipe
  logic adv;

  // stage 1: input register with breakpoint table and region search
  logic     s1_valid;
  in_item_t s1_item;
  region_t  region0;
  region_t  region1;
  logic     take;

  // stage 2: job issue, one result per cycle while the pipe advances
  logic                         s2_valid_r;
  in_item_t                     s2_item_r;
  region_t                      s2_reg_r [2];
  logic [1:0]                   j_r;
  logic [1:0]                   cnt0;
  logic [2:0]                   n_w;
  logic [1:0]                   last_idx;
  logic                         s2_fuzz;
  logic                         s2_done;
  logic                         job_ch;
  logic [TERM_W-1:0]            job_term;
  logic [AW-1:0]                job_addr;
  logic [AW-1:0]                ld_addr;
  logic                         ld_we;
  logic signed [VALUE_BITS-1:0] peak_r [2*TERMS];
  logic signed [VALUE_BITS-1:0] sup_r  [2*TERMS];

  // stage 3 and 4: job register, offset and saturation check
  job_t                         j1_r;
  job_t                         j1_nxt;
  div_t                         div0_r;
  div_t                         div0_nxt;
  logic signed [VALUE_BITS:0]   diff;
  logic [VALUE_BITS-1:0]        absd;

  div_t                         div_w [DIV_STAGES+1];

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_nxt;

  assign adv = !(out_valid_r && out_stall);

  // ---------------------------------------------------------------- stage 1
  assign take     = adv && s1_valid && (!s2_valid_r || s2_done);
  assign in_stall = !adv || (s1_valid && !take);

  tfz_locate #(
    .TERMS(TERMS)
  ) u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .capture  (in_valid && !in_stall),
    .in_item  (in_data),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .region0  (region0),
    .region1  (region1)
  );

  // ---------------------------------------------------------------- stage 2
  assign s2_fuzz  = s2_item_r.operation == OP_FUZZ;
  assign cnt0     = s2_reg_r[0].pair ? 2'd2 : 2'd1;
  assign n_w      = 3'(cnt0) + (s2_reg_r[1].pair ? 3'd2 : 3'd1);
  assign last_idx = 2'(n_w - 3'd1);
  assign s2_done  = s2_valid_r && (!s2_fuzz || j_r == last_idx);

  // results of channel 0 come first, then channel 1
  always_comb begin
    logic [1:0] sub;
    job_ch   = j_r >= cnt0;
    sub      = job_ch ? j_r - cnt0 : j_r;
    job_term = s2_reg_r[job_ch].base + TERM_W'(sub);
    job_addr = AW'(int'(job_ch) * TERMS + int'(job_term));
  end

  // peaks and supports follow the request order: written as the load
  // passes job issue, after every earlier fuzzify has read them
  assign ld_we   = adv && s2_valid_r && !s2_fuzz && int'(s2_item_r.load_index) < TERMS;
  assign ld_addr = AW'(int'(s2_item_r.load_channel) * TERMS + int'(s2_item_r.load_index));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      j_r        <= '0;
    end else if (adv) begin
      if (take) begin
        s2_valid_r <= 1'b1;
        j_r        <= '0;
      end else if (s2_done) begin
        s2_valid_r <= 1'b0;
      end else if (s2_valid_r) begin
        j_r <= j_r + 2'd1;
      end
    end
    if (take) begin
      s2_item_r   <= s1_item;
      s2_reg_r[0] <= region0;
      s2_reg_r[1] <= region1;
    end
    if (ld_we) begin
      case (s2_item_r.load_kind)
        KIND_PEAK:    peak_r[ld_addr] <= s2_item_r.load_value;
        KIND_SUPPORT: sup_r[ld_addr]  <= s2_item_r.load_value;
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    j1_nxt.valid   = s2_valid_r && s2_fuzz;
    j1_nxt.channel = job_ch;
    j1_nxt.term    = job_term;
    j1_nxt.last    = j_r == last_idx;
    j1_nxt.full    = !s2_reg_r[job_ch].pair;
    j1_nxt.v       = job_ch ? s2_item_r.trend : s2_item_r.deviation;
    j1_nxt.p       = peak_r[job_addr];
    j1_nxt.s       = sup_r[job_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j1_r.valid <= 1'b0;
    end else if (adv) begin
      j1_r <= j1_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // 2|v - peak| becomes the first remainder; outside the end regions, at or
  // above support, or with a support that is not positive, the membership is zero
  always_comb begin
    diff = {j1_r.v[VALUE_BITS-1], j1_r.v} - {j1_r.p[VALUE_BITS-1], j1_r.p};
    absd = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : diff[VALUE_BITS-1:0];
    div0_nxt.valid   = j1_r.valid;
    div0_nxt.channel = j1_r.channel;
    div0_nxt.term    = j1_r.term;
    div0_nxt.last    = j1_r.last;
    div0_nxt.full    = j1_r.full;
    div0_nxt.r       = {absd, 1'b0};
    div0_nxt.s       = RW'(unsigned'(j1_r.s));
    div0_nxt.q       = '0;
    div0_nxt.zero    = !j1_r.full &&
                       (j1_r.s[VALUE_BITS-1] || j1_r.s == '0 || div0_nxt.r >= div0_nxt.s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div0_r.valid <= 1'b0;
    end else if (adv) begin
      div0_r <= div0_nxt;
    end
  end

  // ---------------------------------------------------------- divider pipe
  assign div_w[0] = div0_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tfz_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_in  (div_w[g]),
      .d_out (div_w[g+1])
    );
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_nxt.channel = div_w[DIV_STAGES].channel;
    out_nxt.term    = div_w[DIV_STAGES].term;
    out_nxt.last    = div_w[DIV_STAGES].last;
    if (div_w[DIV_STAGES].full) begin
      out_nxt.membership = ONE_Q15;
    end else if (div_w[DIV_STAGES].zero) begin
      out_nxt.membership = '0;
    end else begin
      out_nxt.membership = ONE_Q15 - {1'b0, div_w[DIV_STAGES].q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_w[DIV_STAGES].valid;
    end
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------ assertions
  a_job_idx: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_fuzz |-> j_r <= last_idx)
    else $error("job index beyond result count");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s2_valid_r && !s2_done |-> in_stall)
    else $error("request taken while job issue busy");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    div0_r.valid && div0_r.full |-> !div0_r.zero)
    else $error("shoulder result flagged zero");

  a_mu_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.membership <= ONE_Q15)
    else $error("membership above one");

endmodule

FILE: design/tfz_locate.sv
module tfz_locate #(
  parameter int TERMS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               capture,
  input  tfz_pkg::in_item_t  in_item,
  input  logic               take,
  output logic               s1_valid,
  output tfz_pkg::in_item_t  s1_item,
  output tfz_pkg::region_t   region0,
  output tfz_pkg::region_t   region1
);
  import tfz_pkg::*;

  localparam int AW = $clog2(2 * TERMS);

  logic                         s1_valid_r;
  in_item_t                     s1_item_r;
  logic signed [VALUE_BITS-1:0] bp_r [2*TERMS];
  logic                         bp_we;
  logic [AW-1:0]                bp_addr;
  region_t                      reg_w [2];

  assign bp_we = take && s1_item_r.operation == OP_LOAD &&
                 s1_item_r.load_kind == KIND_BP &&
                 int'(s1_item_r.load_index) < TERMS;
  assign bp_addr = AW'(int'(s1_item_r.load_channel) * TERMS + int'(s1_item_r.load_index));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (capture) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
    if (capture) begin
      s1_item_r <= in_item;
    end
    if (bp_we) begin
      bp_r[bp_addr] <= s1_item_r.load_value;
    end
  end

  // first breakpoint at or above the sample, shoulders at both ends
  always_comb begin
    logic signed [VALUE_BITS-1:0] v;
    logic                         found;
    for (int c = 0; c < 2; c++) begin
      v = (c == 1) ? s1_item_r.trend : s1_item_r.deviation;
      found = 1'b0;
      reg_w[c].base = TERM_W'(TERMS - 1);
      reg_w[c].pair = 1'b0;
      if (v <= bp_r[c * TERMS]) begin
        reg_w[c].base = '0;
      end else begin
        for (int k = 1; k < TERMS; k++) begin
          if (!found && v <= bp_r[c * TERMS + k]) begin
            found = 1'b1;
            reg_w[c].base = TERM_W'(k - 1);
            reg_w[c].pair = 1'b1;
          end
        end
      end
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
  assign region0  = reg_w[0];
  assign region1  = reg_w[1];

endmodule

FILE: design/tfz_div_stage.sv
module tfz_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  tfz_pkg::div_t d_in,
  output tfz_pkg::div_t d_out
);
  import tfz_pkg::*;

  div_t d_r;
  div_t d_nxt;

  // restoring division, three quotient bits per stage
  always_comb begin
    logic [RW-1:0] r;
    d_nxt = d_in;
    r = d_in.r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[RW-2:0], 1'b0};
      if (r >= d_in.s) begin
        r = r - d_in.s;
        d_nxt.q = {d_nxt.q[QB-2:0], 1'b1};
      end else begin
        d_nxt.q = {d_nxt.q[QB-2:0], 1'b0};
      end
    end
    d_nxt.r = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
